// ===== sv/solar_to_lunar_date_defines.svh =====
// Assertion macros shared by the solar-to-lunar date converter RTL.
// Included by modules that check their own control logic; no other dependencies.
// Checks compile away when SYNTHESIS is defined.
`ifndef SOLAR_TO_LUNAR_DATE_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_DEFINES_SVH
`ifndef SYNTHESIS
`define S2L_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define S2L_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S2L_ASSERT(lbl, prop, msg)
`define S2L_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/s2l_pkg.sv =====
// Package for the solar-to-lunar date converter: lunar year table, date helpers,
// FSM state type and the result struct. No dependencies.
package s2l_pkg;

  localparam int S2L_FIRST_YEAR = 1900;
  localparam int S2L_YEAR_COUNT = 150;
  localparam int S2L_ROM_WORDS  = 150;
  localparam int S2L_WORD_W     = 17;
  localparam int S2L_YLEN_W     = 9;
  localparam int S2L_ENTRY_W    = S2L_WORD_W + S2L_YLEN_W;

  // Per-year word: leap month in [3:0], month 1..12 long flags in [15:4], leap length in [16]
  localparam logic [S2L_WORD_W-1:0] S2L_ROM [S2L_ROM_WORDS] = '{
    17'h04BD8, 17'h04AE0, 17'h0A570, 17'h054D5, 17'h0D260,
    17'h0D950, 17'h16554, 17'h056A0, 17'h09AD0, 17'h055D2,
    17'h04AE0, 17'h0A5B6, 17'h0A4D0, 17'h0D250, 17'h1D255,
    17'h0B540, 17'h0D6A0, 17'h0ADA2, 17'h095B0, 17'h14977,
    17'h04970, 17'h0A4B0, 17'h0B4B5, 17'h06A50, 17'h06D40,
    17'h1AB54, 17'h02B60, 17'h09570, 17'h052F2, 17'h04970,
    17'h06566, 17'h0D4A0, 17'h0EA50, 17'h06E95, 17'h05AD0,
    17'h02B60, 17'h186E3, 17'h092E0, 17'h1C8D7, 17'h0C950,
    17'h0D4A0, 17'h1D8A6, 17'h0B550, 17'h056A0, 17'h1A5B4,
    17'h025D0, 17'h092D0, 17'h0D2B2, 17'h0A950, 17'h0B557,
    17'h06CA0, 17'h0B550, 17'h15355, 17'h04DA0, 17'h0A5D0,
    17'h14573, 17'h052D0, 17'h0A9A8, 17'h0E950, 17'h06AA0,
    17'h0AEA6, 17'h0AB50, 17'h04B60, 17'h0AAE4, 17'h0A570,
    17'h05260, 17'h0F263, 17'h0D950, 17'h05B57, 17'h056A0,
    17'h096D0, 17'h04DD5, 17'h04AD0, 17'h0A4D0, 17'h0D4D4,
    17'h0D250, 17'h0D558, 17'h0B540, 17'h0B5A0, 17'h195A6,
    17'h095B0, 17'h049B0, 17'h0A974, 17'h0A4B0, 17'h0B27A,
    17'h06A50, 17'h06D40, 17'h0AF46, 17'h0AB60, 17'h09570,
    17'h04AF5, 17'h04970, 17'h064B0, 17'h074A3, 17'h0EA50,
    17'h06B58, 17'h05AC0, 17'h0AB60, 17'h096D5, 17'h092E0,
    17'h0C960, 17'h0D954, 17'h0D4A0, 17'h0DA50, 17'h07552,
    17'h056A0, 17'h0ABB7, 17'h025D0, 17'h092D0, 17'h0CAB5,
    17'h0A950, 17'h0B4A0, 17'h0BAA4, 17'h0AD50, 17'h055D9,
    17'h04BA0, 17'h0A5B0, 17'h15176, 17'h052B0, 17'h0A930,
    17'h07954, 17'h06AA0, 17'h0AD50, 17'h05B52, 17'h04B60,
    17'h0A6E6, 17'h0A4E0, 17'h0D260, 17'h0EA65, 17'h0D530,
    17'h05AA0, 17'h076A3, 17'h096D0, 17'h04AFB, 17'h04AD0,
    17'h0A4D0, 17'h1D0B6, 17'h0D250, 17'h0D520, 17'h0DD45,
    17'h0B5A0, 17'h056D0, 17'h055B2, 17'h049B0, 17'h0A577,
    17'h0A4B0, 17'h0AA50, 17'h1B255, 17'h06D20, 17'h0ADA0
  };

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SYEAR,
    ST_SMON,
    ST_LWALK,
    ST_MWALK,
    ST_FIN
  } s2l_state_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        is_leap_month;
    logic        date_valid;
  } s2l_res_t;

  function automatic logic [S2L_WORD_W-1:0] rom_word(input logic [7:0] i);
    if (i < 8'(S2L_ROM_WORDS)) return S2L_ROM[i];
    return '0;
  endfunction

  // Leap month number, zero when none or out of range
  function automatic logic [3:0] leap_of(input logic [S2L_WORD_W-1:0] w);
    return (w[3:0] <= 4'd12) ? w[3:0] : 4'd0;
  endfunction

  function automatic logic [4:0] leap_len(input logic [S2L_WORD_W-1:0] w);
    if (leap_of(w) == 4'd0) return 5'd0;
    return w[16] ? 5'd30 : 5'd29;
  endfunction

  // Regular lunar month length, month m in 1..12
  function automatic logic [4:0] mon_len(input logic [S2L_WORD_W-1:0] w,
                                         input logic [3:0] m);
    logic [4:0] b;
    b = 5'd16 - {1'b0, m};
    return w[b] ? 5'd30 : 5'd29;
  endfunction

  function automatic logic [S2L_YLEN_W-1:0] year_len(input logic [S2L_WORD_W-1:0] w);
    logic [S2L_YLEN_W-1:0] days;
    days = 9'd348;
    for (int b = 4; b <= 15; b++) begin
      days = days + 9'(w[b]);
    end
    return days + 9'(leap_len(w));
  endfunction

  // Gregorian month length
  function automatic logic [4:0] greg_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                       n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
      default:                    n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/s2l_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module s2l_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/s2l_walk.sv =====
// Conversion sequencer: loads the year table into RAM, then walks solar days,
// lunar years and lunar months. Depends on s2l_pkg, s2l_ram and the defines header.
`include "solar_to_lunar_date_defines.svh"
module s2l_walk import s2l_pkg::*; #(
  parameter int YEAR_COUNT = S2L_YEAR_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_solar_year,
  input  logic [3:0]  in_solar_month,
  input  logic [4:0]  in_solar_day,
  output s2l_res_t    res,
  input  logic        res_take
);

  localparam int COUNT = (YEAR_COUNT < S2L_ROM_WORDS) ? YEAR_COUNT : S2L_ROM_WORDS;
  localparam int AW    = (COUNT > 1) ? $clog2(COUNT) : 1;
  localparam int IW    = $clog2(COUNT + 1);
  localparam int TW    = $clog2((COUNT + 2) * 366);

  s2l_state_t state_r, state_nxt;
  logic [IW-1:0] fill_r, fill_nxt;
  logic [11:0]   y_r, y_nxt;
  logic [3:0]    m_r, m_nxt;
  logic [4:0]    d_r, d_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [IW-1:0] yoff_r, yoff_nxt;
  logic [1:0]    c4_r, c4_nxt;
  logic [6:0]    c100_r, c100_nxt;
  logic [8:0]    c400_r, c400_nxt;
  logic [3:0]    mon_r, mon_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [S2L_WORD_W-1:0] w_r, w_nxt;
  logic [3:0]    lm_r, lm_nxt;
  logic          inlp_r, inlp_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          dval_r, dval_nxt;

  logic                   ram_we;
  logic [S2L_WORD_W-1:0]  fill_word;
  logic [S2L_ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]          ram_raddr;
  logic                   leap_yr;
  logic [11:0]            ytgt;
  logic [TW-1:0]          t2;
  logic [S2L_YLEN_W-1:0]  ylen;
  logic [S2L_WORD_W-1:0]  yword;
  logic [4:0]             mlen;
  logic [3:0]             lm_inc;
  logic                   bad_in;

  // Year table RAM: {word, precomputed year length}
  s2l_ram #(
    .WIDTH (S2L_ENTRY_W),
    .DEPTH (COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fill_word = rom_word(8'(fill_r));
  assign ram_wdata = {fill_word, year_len(fill_word)};
  assign yword     = ram_rdata[S2L_ENTRY_W-1:S2L_YLEN_W];
  assign ylen      = ram_rdata[S2L_YLEN_W-1:0];

  // Address follows the next index so data for idx_r is ready in LWALK
  assign ram_raddr = (idx_nxt < IW'(COUNT)) ? idx_nxt[AW-1:0] : '0;

  assign leap_yr = ((c4_r == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign ytgt    = y_r - 12'(S2L_FIRST_YEAR);
  assign t2      = total_r + TW'(d_r);
  assign mlen    = inlp_r ? leap_len(w_r) : mon_len(w_r, lm_r);
  assign lm_inc  = lm_r + 4'd1;
  assign bad_in  = (in_solar_year < 12'(S2L_FIRST_YEAR)) ||
                   (in_solar_year > 12'(S2L_FIRST_YEAR + COUNT)) ||
                   (in_solar_month == 4'd0) || (in_solar_month > 4'd12) ||
                   (in_solar_day == 5'd0);

  assign in_stall = (state_r != ST_IDLE);

  // Result view, fields zero for an invalid date
  always_comb begin
    res.vld           = (state_r == ST_FIN);
    res.date_valid    = dval_r;
    res.lunar_year    = dval_r ? (12'(S2L_FIRST_YEAR) + 12'(idx_r)) : 12'd0;
    res.lunar_month   = dval_r ? lm_r : 4'd0;
    res.lunar_day     = dval_r ? 5'(total_r + TW'(1)) : 5'd0;
    res.is_leap_month = dval_r & inlp_r;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    m_r     <= m_nxt;
    d_r     <= d_nxt;
    total_r <= total_nxt;
    yoff_r  <= yoff_nxt;
    c4_r    <= c4_nxt;
    c100_r  <= c100_nxt;
    c400_r  <= c400_nxt;
    mon_r   <= mon_nxt;
    idx_r   <= idx_nxt;
    w_r     <= w_nxt;
    lm_r    <= lm_nxt;
    inlp_r  <= inlp_nxt;
    step_r  <= step_nxt;
    dval_r  <= dval_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    total_nxt = total_r;
    yoff_nxt  = yoff_r;
    c4_nxt    = c4_r;
    c100_nxt  = c100_r;
    c400_nxt  = c400_r;
    mon_nxt   = mon_r;
    idx_nxt   = idx_r;
    w_nxt     = w_r;
    lm_nxt    = lm_r;
    inlp_nxt  = inlp_r;
    step_nxt  = step_r;
    dval_nxt  = dval_r;
    ram_we    = 1'b0;
    case (state_r)
      // Copy the constant table into RAM, one entry per cycle
      ST_FILL: begin
        ram_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == IW'(COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          y_nxt     = in_solar_year;
          m_nxt     = in_solar_month;
          d_nxt     = in_solar_day;
          total_nxt = '0;
          yoff_nxt  = '0;
          c4_nxt    = 2'(S2L_FIRST_YEAR % 4);
          c100_nxt  = 7'(S2L_FIRST_YEAR % 100);
          c400_nxt  = 9'(S2L_FIRST_YEAR % 400);
          lm_nxt    = 4'd1;
          inlp_nxt  = 1'b0;
          if (bad_in) begin
            dval_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SYEAR;
          end
        end
      end
      // Whole Gregorian years since the first year
      ST_SYEAR: begin
        if (12'(yoff_r) != ytgt) begin
          total_nxt = total_r + (leap_yr ? TW'(366) : TW'(365));
          yoff_nxt  = yoff_r + 1'b1;
          c4_nxt    = c4_r + 2'd1;
          c100_nxt  = (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
          c400_nxt  = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
        end else begin
          mon_nxt   = 4'd1;
          state_nxt = ST_SMON;
        end
      end
      // Gregorian months, then day check and epoch offset
      ST_SMON: begin
        if (mon_r != m_r) begin
          total_nxt = total_r + TW'(greg_len(mon_r, leap_yr));
          mon_nxt   = mon_r + 4'd1;
        end else if ((d_r > greg_len(m_r, leap_yr)) || (t2 < TW'(31))) begin
          dval_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          total_nxt = t2 - TW'(31);
          idx_nxt   = '0;
          state_nxt = ST_LWALK;
        end
      end
      // Whole lunar years from the RAM
      ST_LWALK: begin
        if (idx_r == IW'(COUNT)) begin
          dval_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else if (total_r >= TW'(ylen)) begin
          total_nxt = total_r - TW'(ylen);
          idx_nxt   = idx_r + 1'b1;
        end else begin
          w_nxt     = yword;
          lm_nxt    = 4'd1;
          inlp_nxt  = 1'b0;
          step_nxt  = 4'd0;
          state_nxt = ST_MWALK;
        end
      end
      // Lunar months of the found year
      ST_MWALK: begin
        if ((step_r < 4'd13) && (total_r >= TW'(mlen))) begin
          total_nxt = total_r - TW'(mlen);
          step_nxt  = step_r + 4'd1;
          if ((leap_of(w_r) != 4'd0) && (lm_r == leap_of(w_r)) && !inlp_r) begin
            inlp_nxt = 1'b1;
          end else begin
            inlp_nxt = 1'b0;
            if (lm_inc > 4'd12) begin
              lm_nxt    = 4'd12;
              dval_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              lm_nxt = lm_inc;
            end
          end
        end else begin
          dval_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `S2L_ASSERT_RST(a_rst_fill, !rst_n |=> state_r == ST_FILL, "reset must start the table fill")
  `S2L_ASSERT(a_idx_range, state_r == ST_LWALK |-> idx_r <= IW'(COUNT), "year index overran")
  `S2L_ASSERT(a_month_range, state_r == ST_MWALK |-> (lm_r >= 4'd1 && lm_r <= 4'd12), "bad month")
  `S2L_ASSERT(a_take_idle, res_take |=> state_r == ST_IDLE, "result taken but not idle")

endmodule

// ===== sv/solar_to_lunar_date.sv =====
// Gregorian to Chinese lunar date converter, top level with the result register.
// Depends on s2l_pkg and s2l_walk.
//
// Usage: a request on the in_ channel (in_valid high, in_stall low at a clock edge)
// carries a Gregorian year, month and day. Each request yields one result on the
// out_ channel: lunar year, month, day, leap-month flag and date_valid. Invalid or
// out-of-table dates return date_valid low with all other fields zero.
// After reset (rst_n low, synchronous) the year table is copied into RAM, one word
// per cycle, YEAR_COUNT words (at most 150); in_stall stays high meanwhile.
// A request walks whole Gregorian years from 1900, then the months of its year, then
// whole lunar years and lunar months (up to 13); a request with bad fields or a
// year outside 1900 to 1900 + table size goes straight to the result. The cost
// is set by the year counters and one RAM read per lunar year. One request is in
// work at a time; a new request is taken while the last result still waits in the
// output register. While out_stall is high the result holds; the sequencer waits
// with its next result until the output register frees.
module solar_to_lunar_date import s2l_pkg::*; #(
  parameter int YEAR_COUNT = S2L_YEAR_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_solar_year,
  input  logic [3:0]  in_solar_month,
  input  logic [4:0]  in_solar_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_lunar_year,
  output logic [3:0]  out_lunar_month,
  output logic [4:0]  out_lunar_day,
  output logic        out_is_leap_month,
  output logic        out_date_valid
);

  s2l_res_t res;
  logic     res_take;
  logic     out_valid_r, out_valid_nxt;
  s2l_res_t out_r;

  s2l_walk #(
    .YEAR_COUNT (YEAR_COUNT)
  ) u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_solar_year  (in_solar_year),
    .in_solar_month (in_solar_month),
    .in_solar_day   (in_solar_day),
    .res            (res),
    .res_take       (res_take)
  );

  // Output register takes a result when empty or being drained
  assign res_take = res.vld && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lunar_year    = out_r.lunar_year;
  assign out_lunar_month   = out_r.lunar_month;
  assign out_lunar_day     = out_r.lunar_day;
  assign out_is_leap_month = out_r.is_leap_month;
  assign out_date_valid    = out_r.date_valid;

endmodule
